>>> design/cdms_pkg.sv
package cdms_pkg;

	localparam int MOMENTUM_BITS = 24;
	localparam int START_W       = 17;
	localparam int INC_W         = 16;
	localparam int COUNT_REG_W   = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int STEP_W        = 5;
	localparam int MASS_W        = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_START     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_INCREMENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_COUNT     = 2'd2;

	localparam logic [START_W-1:0]     RST_SCALE_START     = 17'd49152;
	localparam logic [INC_W-1:0]       RST_SCALE_INCREMENT = 16'd1638;
	localparam logic [COUNT_REG_W-1:0] RST_SCALE_COUNT     = 6'd20;

	localparam int DEF_MAX_SCALE_STEPS = 32;
	localparam int SCALE_W  = 23;
	localparam int PROD_W   = 2 * MOMENTUM_BITS;
	localparam int DIFF_W   = PROD_W + 1;
	localparam int Q_W      = PROD_W + 1;
	localparam int V_W      = PROD_W + 16;
	localparam int U_W      = PROD_W + SCALE_W + 1;
	localparam int NUM_W    = Q_W + 2 * U_W + 21;
	localparam int DEN_W    = 2 * PROD_W + 20 + 32;
	localparam int QUO_W    = 48;
	localparam int DSH_W    = DEN_W + QUO_W - 1;
	localparam int QDEPTH   = 4;
	localparam int DEN_SCALE = 1000000;
	localparam logic [MASS_W-1:0] MASS_SAT = {MASS_W{1'b1}};

	typedef struct packed {
		logic signed [MOMENTUM_BITS-1:0] miss_x;
		logic signed [MOMENTUM_BITS-1:0] miss_y;
		logic signed [MOMENTUM_BITS-1:0] lep_px;
		logic signed [MOMENTUM_BITS-1:0] lep_py;
		logic signed [MOMENTUM_BITS-1:0] lep_pz;
		logic        [MOMENTUM_BITS-1:0] lep_p;
		logic signed [MOMENTUM_BITS-1:0] jet_px;
		logic signed [MOMENTUM_BITS-1:0] jet_py;
		logic signed [MOMENTUM_BITS-1:0] jet_pz;
		logic        [MOMENTUM_BITS-1:0] jet_p;
	} in_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_index;
		logic [MASS_W-1:0] mass_gev;
		logic              mass_valid;
		logic              last_step;
	} out_item_t;

	typedef struct packed {
		logic [PROD_W-1:0] abs_d;
		logic [PROD_W-1:0] abs_n1;
		logic [PROD_W-1:0] abs_n2;
		logic [Q_W-1:0]    qv;
		logic              base_ok;
		logic              q_pos;
	} work_item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DSQ,
		B_DMIL,
		B_STEP,
		B_U1,
		B_U2,
		B_PMUL,
		B_NMUL,
		B_DIV,
		B_ROOT,
		B_EMIT
	} back_state_t;

endpackage

>>> design/cdms_front.sv
module cdms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdms_pkg::in_item_t  in_data,
	output logic                push,
	output cdms_pkg::work_item_t push_data,
	input  logic                q_full
);
	import cdms_pkg::*;

	logic v1_q, v2_q, adv1, adv2;

	logic signed [PROD_W-1:0] ly_jx_s1, jy_lx_s1, my_jx_s1, jy_mx_s1, mx_ly_s1, lx_my_s1;
	logic signed [PROD_W-1:0] lx_jx_s1, ly_jy_s1, lz_jz_s1;
	logic        [PROD_W-1:0] pl_pj_s1;
	logic                     nz_s1;

	logic signed [DIFF_W-1:0] d_s2, n1_s2, n2_s2;
	logic        [PROD_W-1:0] possum_s2, negsum_s2, pl_pj_s2;
	logic                     nz_s2;

	logic [PROD_W-1:0] pos0, pos1, pos2, neg0, neg1, neg2;
	logic [DIFF_W-1:0] abs_d_w, abs_n1_w, abs_n2_w;
	logic [Q_W-1:0]    qa;
	logic              q_pos, sd, s1, s2;

	assign adv2     = !v2_q || !q_full;
	assign adv1     = !v1_q || adv2;
	assign in_ready = adv1;
	assign push     = v2_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			ly_jx_s1 <= in_data.lep_py * in_data.jet_px;
			jy_lx_s1 <= in_data.jet_py * in_data.lep_px;
			my_jx_s1 <= in_data.miss_y * in_data.jet_px;
			jy_mx_s1 <= in_data.jet_py * in_data.miss_x;
			mx_ly_s1 <= in_data.miss_x * in_data.lep_py;
			lx_my_s1 <= in_data.lep_px * in_data.miss_y;
			lx_jx_s1 <= in_data.lep_px * in_data.jet_px;
			ly_jy_s1 <= in_data.lep_py * in_data.jet_py;
			lz_jz_s1 <= in_data.lep_pz * in_data.jet_pz;
			pl_pj_s1 <= in_data.lep_p * in_data.jet_p;
			nz_s1    <= (in_data.jet_px != '0) && (in_data.lep_p != '0) &&
				(in_data.jet_p != '0);
		end
	end

	always_comb begin
		pos0 = lx_jx_s1[PROD_W-1] ? '0 : lx_jx_s1;
		pos1 = ly_jy_s1[PROD_W-1] ? '0 : ly_jy_s1;
		pos2 = lz_jz_s1[PROD_W-1] ? '0 : lz_jz_s1;
		neg0 = lx_jx_s1[PROD_W-1] ? PROD_W'(-lx_jx_s1) : '0;
		neg1 = ly_jy_s1[PROD_W-1] ? PROD_W'(-ly_jy_s1) : '0;
		neg2 = lz_jz_s1[PROD_W-1] ? PROD_W'(-lz_jz_s1) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			d_s2      <= DIFF_W'(ly_jx_s1) - DIFF_W'(jy_lx_s1);
			n1_s2     <= DIFF_W'(my_jx_s1) - DIFF_W'(jy_mx_s1);
			n2_s2     <= DIFF_W'(mx_ly_s1) - DIFF_W'(lx_my_s1);
			possum_s2 <= pos0 + pos1 + pos2;
			negsum_s2 <= neg0 + neg1 + neg2;
			pl_pj_s2  <= pl_pj_s1;
			nz_s2     <= nz_s1;
		end
	end

	always_comb begin
		sd       = d_s2[DIFF_W-1];
		s1       = n1_s2[DIFF_W-1];
		s2       = n2_s2[DIFF_W-1];
		abs_d_w  = sd ? DIFF_W'(-d_s2) : DIFF_W'(d_s2);
		abs_n1_w = s1 ? DIFF_W'(-n1_s2) : DIFF_W'(n1_s2);
		abs_n2_w = s2 ? DIFF_W'(-n2_s2) : DIFF_W'(n2_s2);
		qa       = Q_W'(pl_pj_s2) + Q_W'(negsum_s2);
		q_pos    = qa > Q_W'(possum_s2);
		push_data.abs_d   = abs_d_w[PROD_W-1:0];
		push_data.abs_n1  = abs_n1_w[PROD_W-1:0];
		push_data.abs_n2  = abs_n2_w[PROD_W-1:0];
		push_data.qv      = q_pos ? qa - Q_W'(possum_s2) : '0;
		push_data.q_pos   = q_pos;
		push_data.base_ok = nz_s2 && (d_s2 != '0) && (n1_s2 != '0) && (n2_s2 != '0) &&
			(s1 == sd) && (s2 == sd);
	end

endmodule

>>> design/cdms_queue.sv
module cdms_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cdms_pkg::work_item_t push_data,
	output logic                 full,
	input  logic                 pop,
	output cdms_pkg::work_item_t pop_data,
	output logic                 empty
);
	import cdms_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	work_item_t      entries_q [QDEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     cnt_q;

	assign full     = cnt_q == (AW+1)'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

>>> design/cdms_serial_mul.sv
module cdms_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cdms_pkg::NUM_W-1:0]  a,
	input  logic [cdms_pkg::U_W-1:0]    b,
	output logic                        done,
	output logic [cdms_pkg::NUM_W-1:0]  result
);
	import cdms_pkg::*;

	logic             busy_q;
	logic [NUM_W-1:0] a_q, acc_q;
	logic [U_W-1:0]   b_q;

	assign done   = busy_q && (b_q == '0);
	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (start) busy_q <= 1'b1;
		else if (done) busy_q <= 1'b0;
	end

	// shift and add, one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

>>> design/cdms_back.sv
module cdms_back #(
	parameter int MAX_SCALE_STEPS = cdms_pkg::DEF_MAX_SCALE_STEPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	input  cdms_pkg::work_item_t                  q_data,
	output logic                                  pop,
	input  logic [cdms_pkg::START_W-1:0]          scale_start,
	input  logic [cdms_pkg::INC_W-1:0]            scale_increment,
	input  logic [$clog2(MAX_SCALE_STEPS+1)-1:0]  count,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output cdms_pkg::out_item_t                   out_data
);
	import cdms_pkg::*;

	localparam int KW = $clog2(MAX_SCALE_STEPS + 1);

	back_state_t state_q, state_d;
	work_item_t  item_q, item_d;
	logic [KW-1:0]      k_q, k_d;
	logic [SCALE_W-1:0] s_q, s_d;
	logic [DEN_W-1:0]   den_q, den_d;
	logic [U_W-1:0]     u1_q, u1_d;
	logic [NUM_W-1:0]   rem_q, rem_d, num_w;
	logic [DSH_W-1:0]   dsh_q, dsh_d;
	logic [QUO_W-1:0]   quo_q, quo_d, quo_next;
	logic [5:0]         bitcnt_q, bitcnt_d;
	logic [QUO_W-1:0]   sq_q, sq_d, root_q, root_d, sbit_q, sbit_d;
	logic [QUO_W:0]     root_sum;
	logic [MASS_W-1:0]  mass_q, mass_d;
	logic               mvalid_q, mvalid_d;
	logic [V_W-1:0]     v_ext;
	logic               ge, out_load, out_valid_q;
	out_item_t          out_data_q;

	logic             mul_start, mul_done;
	logic [NUM_W-1:0] mul_a, mul_res;
	logic [U_W-1:0]   mul_b;

	cdms_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	assign v_ext     = {item_q.abs_d, 16'b0};
	assign num_w     = mul_res << 21;
	assign ge        = rem_q >= NUM_W'(dsh_q);
	assign quo_next  = {quo_q[QUO_W-2:0], ge};
	assign root_sum  = {1'b0, root_q} + {1'b0, sbit_q};
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		item_q   <= item_d;
		k_q      <= k_d;
		s_q      <= s_d;
		den_q    <= den_d;
		u1_q     <= u1_d;
		rem_q    <= rem_d;
		dsh_q    <= dsh_d;
		quo_q    <= quo_d;
		bitcnt_q <= bitcnt_d;
		sq_q     <= sq_d;
		root_q   <= root_d;
		sbit_q   <= sbit_d;
		mass_q   <= mass_d;
		mvalid_q <= mvalid_d;
		if (out_load) begin
			out_data_q.step_index <= STEP_W'(k_q);
			out_data_q.mass_gev   <= mass_q;
			out_data_q.mass_valid <= mvalid_q;
			out_data_q.last_step  <= KW'(k_q + 1'b1) == count;
		end
	end

	always_comb begin
		state_d  = state_q;
		item_d   = item_q;
		k_d      = k_q;
		s_d      = s_q;
		den_d    = den_q;
		u1_d     = u1_q;
		rem_d    = rem_q;
		dsh_d    = dsh_q;
		quo_d    = quo_q;
		bitcnt_d = bitcnt_q;
		sq_d     = sq_q;
		root_d   = root_q;
		sbit_d   = sbit_q;
		mass_d   = mass_q;
		mvalid_d = mvalid_q;
		pop       = 1'b0;
		out_load  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop    = 1'b1;
					item_d = q_data;
					k_d    = '0;
					s_d    = SCALE_W'(scale_start);
					if (q_data.base_ok && q_data.q_pos) begin
						mul_start = 1'b1;
						mul_a     = NUM_W'(q_data.abs_d);
						mul_b     = U_W'(q_data.abs_d);
						state_d   = B_DSQ;
					end else begin
						state_d = B_STEP;
					end
				end
			end
			B_DSQ: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_res;
					mul_b     = U_W'(DEN_SCALE);
					state_d   = B_DMIL;
				end
			end
			B_DMIL: begin
				if (mul_done) begin
					den_d   = {mul_res[DEN_W-33:0], 32'b0};
					state_d = B_STEP;
				end
			end
			B_STEP: begin
				if (item_q.base_ok && item_q.q_pos && (s_q != '0)) begin
					mul_start = 1'b1;
					mul_a     = NUM_W'(item_q.abs_n1);
					mul_b     = U_W'(s_q);
					state_d   = B_U1;
				end else begin
					mass_d   = '0;
					mvalid_d = item_q.base_ok && (s_q != '0);
					state_d  = B_EMIT;
				end
			end
			B_U1: begin
				if (mul_done) begin
					u1_d      = U_W'(mul_res) + U_W'(v_ext);
					mul_start = 1'b1;
					mul_a     = NUM_W'(item_q.abs_n2);
					mul_b     = U_W'(s_q);
					state_d   = B_U2;
				end
			end
			B_U2: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = NUM_W'(u1_q);
					mul_b     = U_W'(mul_res) + U_W'(v_ext);
					state_d   = B_PMUL;
				end
			end
			B_PMUL: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_res;
					mul_b     = U_W'(item_q.qv);
					state_d   = B_NMUL;
				end
			end
			B_NMUL: begin
				if (mul_done) begin
					if (num_w >= NUM_W'({den_q, {QUO_W{1'b0}}})) begin
						mass_d   = MASS_SAT;
						mvalid_d = 1'b1;
						state_d  = B_EMIT;
					end else begin
						rem_d    = num_w;
						dsh_d    = {den_q, {(QUO_W-1){1'b0}}};
						quo_d    = '0;
						bitcnt_d = 6'(QUO_W - 1);
						state_d  = B_DIV;
					end
				end
			end
			B_DIV: begin
				if (ge) rem_d = rem_q - NUM_W'(dsh_q);
				quo_d    = quo_next;
				dsh_d    = dsh_q >> 1;
				bitcnt_d = bitcnt_q - 1'b1;
				if (bitcnt_q == '0) begin
					sq_d    = quo_next;
					root_d  = '0;
					sbit_d  = QUO_W'(1) << (QUO_W - 2);
					state_d = B_ROOT;
				end
			end
			B_ROOT: begin
				if (sbit_q == '0) begin
					mass_d   = root_q[MASS_W-1:0];
					mvalid_d = 1'b1;
					state_d  = B_EMIT;
				end else begin
					if ({1'b0, sq_q} >= root_sum) begin
						sq_d   = QUO_W'({1'b0, sq_q} - root_sum);
						root_d = (root_q >> 1) + sbit_q;
					end else begin
						root_d = root_q >> 1;
					end
					sbit_d = sbit_q >> 2;
				end
			end
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					if (KW'(k_q + 1'b1) == count) begin
						state_d = B_IDLE;
					end else begin
						k_d     = KW'(k_q + 1'b1);
						s_d     = s_q + SCALE_W'(scale_increment);
						state_d = B_STEP;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.mass_valid || (out_data_q.mass_gev == '0)))
		else $error("invalid mass is not zero");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (den_q != '0))
		else $error("division with zero divisor");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("output transaction changed while stalled");
`endif

endmodule

>>> design/collinear_ditau_mass_scan.sv
// collinear ditau mass scan
// input channel in_valid/in_ready carries one event transaction (missing
// momentum, lepton and tau jet momenta); the output channel out_valid/out_ready
// gives one transaction per scale step, step_index 0 .. count-1, last_step on
// the final one. the front end takes a new event every cycle while its queue
// of four entries has room and classifies it in a product and a sum stage.
// the back end evaluates steps one at a time on a single shift-and-add
// multiplier and bit-serial divide and square-root loops: a step that needs
// the mass runs its products, then the division and the square root unless
// the mass saturates, and products of shorter operands finish sooner; a step
// with an invalid or non-positive result skips them; when the mass is needed
// the divisor is formed first for each event. an event reaches the back end
// via the front-end registers and the queue, its first result after one step.
// configuration writes (cfg_wen, cfg_index, cfg_data) take effect at once; the user
// makes them while the block is idle, which the block itself does not enforce.
// reset clears the pipeline, the queue and the step sequencer and loads the
// default scale registers; no result is pending after reset.
// while out_ready is low the result register holds, the back end waits once its
// next result is ready, and the front end keeps accepting until the queue fills.
module collinear_ditau_mass_scan #(
	parameter int MAX_SCALE_STEPS = cdms_pkg::DEF_MAX_SCALE_STEPS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cdms_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cdms_pkg::out_item_t            out_data,
	input  logic                           cfg_wen,
	input  logic [cdms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdms_pkg::START_W-1:0]   cfg_data
);
	import cdms_pkg::*;

	localparam int KW = $clog2(MAX_SCALE_STEPS + 1);

	logic [START_W-1:0]     scale_start_q;
	logic [INC_W-1:0]       scale_increment_q;
	logic [COUNT_REG_W-1:0] scale_count_q;
	logic [KW-1:0]          count_eff;

	logic       push, q_full, q_empty, pop;
	work_item_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_start_q     <= RST_SCALE_START;
			scale_increment_q <= RST_SCALE_INCREMENT;
			scale_count_q     <= RST_SCALE_COUNT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SCALE_START:     scale_start_q     <= cfg_data;
				CFG_SCALE_INCREMENT: scale_increment_q <= cfg_data[INC_W-1:0];
				CFG_SCALE_COUNT:     scale_count_q     <= cfg_data[COUNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (scale_count_q == '0) count_eff = KW'(1);
		else if (int'(scale_count_q) > MAX_SCALE_STEPS) count_eff = KW'(MAX_SCALE_STEPS);
		else count_eff = KW'(scale_count_q);
	end

	cdms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	cdms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	cdms_back #(
		.MAX_SCALE_STEPS (MAX_SCALE_STEPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (pop_data),
		.pop             (pop),
		.scale_start     (scale_start_q),
		.scale_increment (scale_increment_q),
		.count           (count_eff),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data)
	);

endmodule
